FILE: hw/rtl/cfd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame deframer.
package cfd_pkg;

  // Register map, one 32-bit word per register.
  localparam int unsigned CfgAddrW = 4;

  typedef enum logic [1:0] {
    REG_START_BYTE     = 2'd0,
    REG_CODE_OK        = 2'd1,
    REG_CODE_UNKNOWN   = 2'd2,
    REG_CODE_WRONG_CRC = 2'd3
  } cfd_reg_e;

  // Final status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_START   = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] ST_BAD_COMMAND = 3'd4;
  localparam logic [2:0] ST_BAD_CRC     = 3'd5;

  // Command kinds.
  localparam logic [1:0] KIND_OK        = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN   = 2'd1;
  localparam logic [1:0] KIND_WRONG_CRC = 2'd2;

  // CRC-16 CCITT-FALSE.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Position counter limit and the smallest complete frame.
  localparam logic [8:0] PosMax   = 9'd511;
  localparam logic [9:0] MinFrame = 10'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       done_res;
    logic [2:0] status;
    logic [1:0] command_kind;
    logic [7:0] payload_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] code_ok;
    logic [7:0] code_unknown;
    logic [7:0] code_wrong_crc;
  } cfg_t;

  // One byte of CRC update, MSB first, eight unrolled shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/cfd_regs.sv
// Configuration register bank with an APB-style access port.
module cfd_regs
  import cfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic     wr_en;
  cfd_reg_e wr_sel;
  cfd_reg_e rd_sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_sel = cfd_reg_e'(paddr[CfgAddrW-1:2]);
  assign rd_sel = cfd_reg_e'(paddr[CfgAddrW-1:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte     <= 8'd0;
      cfg.code_ok        <= 8'd0;
      cfg.code_unknown   <= 8'd1;
      cfg.code_wrong_crc <= 8'd2;
    end else if (wr_en) begin
      unique case (wr_sel)
        REG_START_BYTE:     cfg.start_byte     <= pwdata[7:0];
        REG_CODE_OK:        cfg.code_ok        <= pwdata[7:0];
        REG_CODE_UNKNOWN:   cfg.code_unknown   <= pwdata[7:0];
        REG_CODE_WRONG_CRC: cfg.code_wrong_crc <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (rd_sel)
      REG_START_BYTE:     prdata = {24'd0, cfg.start_byte};
      REG_CODE_OK:        prdata = {24'd0, cfg.code_ok};
      REG_CODE_UNKNOWN:   prdata = {24'd0, cfg.code_unknown};
      REG_CODE_WRONG_CRC: prdata = {24'd0, cfg.code_wrong_crc};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/cfd_parse.sv
// Per-frame parse state, CRC accumulation and result formation for one byte.
module cfd_parse
  import cfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      fire,
  output logic      has_result,
  output out_item_t res
);

  logic [8:0]  pos;
  logic [7:0]  length_field;
  logic [7:0]  command_field;
  logic        start_matched;
  logic [15:0] running_crc;
  logic [7:0]  received_crc_high;
  logic [15:0] computed_crc_hold;

  logic [7:0]  b;
  logic        last;
  logic        start_eff;
  logic [7:0]  len;
  logic [7:0]  cmd;
  logic [8:0]  len_p1;
  logic [8:0]  len_p2;
  logic        past_hdr;
  logic        pay;
  logic        crc_upd;
  logic [15:0] crc_next;
  logic        capture;
  logic [7:0]  hi_eff;
  logic [15:0] hold_eff;
  logic [9:0]  frame_size;
  logic [9:0]  len_p4;
  logic        known;
  logic [1:0]  kind;
  logic [2:0]  st;

  assign b    = item.rx_byte;
  assign last = item.frame_end;

  // Header fields as seen by this byte, including a field arriving now.
  assign start_eff = (pos == 9'd0) ? (b == cfg.start_byte) : start_matched;
  assign len       = (pos == 9'd1) ? b : length_field;
  assign cmd       = (pos == 9'd2) ? b : command_field;
  assign len_p1    = {1'b0, len} + 9'd1;
  assign len_p2    = {1'b0, len} + 9'd2;
  assign past_hdr  = pos >= 9'd3;

  // Payload window and CRC coverage.
  assign pay      = past_hdr && (pos <= len_p1);
  assign crc_upd  = (pos <= 9'd2) || (pos <= len_p1);
  assign crc_next = crc_upd ? crc_byte(running_crc, b) : running_crc;

  // First CRC byte: keep it and the CRC computed up to it.
  assign capture  = past_hdr && (pos == len_p2);
  assign hi_eff   = capture ? b : received_crc_high;
  assign hold_eff = capture ? running_crc : computed_crc_hold;

  // Command code lookup, first match wins.
  always_comb begin
    known = 1'b1;
    kind  = KIND_OK;
    if (cmd == cfg.code_ok) begin
      kind = KIND_OK;
    end else if (cmd == cfg.code_unknown) begin
      kind = KIND_UNKNOWN;
    end else if (cmd == cfg.code_wrong_crc) begin
      kind = KIND_WRONG_CRC;
    end else begin
      known = 1'b0;
    end
  end

  // Frame checks in priority order.
  assign frame_size = {1'b0, pos} + 10'd1;
  assign len_p4     = {2'b00, len} + 10'd4;

  always_comb begin
    if (frame_size < MinFrame) begin
      st = ST_TOO_SHORT;
    end else if (!start_eff) begin
      st = ST_BAD_START;
    end else if (len_p4 != frame_size) begin
      st = ST_BAD_LENGTH;
    end else if (!known) begin
      st = ST_BAD_COMMAND;
    end else if ({hi_eff, b} == hold_eff) begin
      st = ST_OK;
    end else begin
      st = ST_BAD_CRC;
    end
  end

  // Result item fields.
  assign has_result = pay || last;

  always_comb begin
    res.payload_byte  = pay ? b : 8'd0;
    res.payload_valid = pay;
    res.done_res      = last;
    res.status        = last ? st : ST_OK;
    res.command_kind  = (last && (st == ST_OK || st == ST_BAD_CRC)) ? kind : KIND_OK;
    res.payload_count = (last && len != 8'd0) ? (len - 8'd1) : 8'd0;
  end

  // Frame state, cleared by the last byte of each frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos               <= 9'd0;
      length_field      <= 8'd0;
      command_field     <= 8'd0;
      start_matched     <= 1'b0;
      running_crc       <= CrcInit;
      received_crc_high <= 8'd0;
      computed_crc_hold <= CrcInit;
    end else if (fire) begin
      if (last) begin
        pos               <= 9'd0;
        length_field      <= 8'd0;
        command_field     <= 8'd0;
        start_matched     <= 1'b0;
        running_crc       <= CrcInit;
        received_crc_high <= 8'd0;
        computed_crc_hold <= CrcInit;
      end else begin
        if (pos != PosMax) begin
          pos <= pos + 9'd1;
        end
        start_matched     <= start_eff;
        length_field      <= len;
        command_field     <= cmd;
        running_crc       <= crc_next;
        received_crc_high <= hi_eff;
        computed_crc_hold <= hold_eff;
      end
    end
  end

endmodule

FILE: hw/rtl/crc16_frame_deframer_core.sv
// Top level of the frame deframer: input register, parser and result register.
// An accepted byte's result item is shown from the result register.
// Throughput: one byte per cycle; the input register holds one byte while the
// result register waits, and bytes that cause no result never wait on it.
// Reset (rst, synchronous, active high) empties both registers, clears the
// frame state and loads the configuration registers with their defaults.
module crc16_frame_deframer_core
  import cfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  in_item_t            frame,
  output logic                result_valid,
  input  logic                result_stall,
  output out_item_t           result
);

  cfg_t      cfg;
  logic      in_q_valid;
  in_item_t  in_q;
  logic      has_result;
  out_item_t res;
  logic      out_free;
  logic      fire;

  cfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (in_q),
    .fire       (fire),
    .has_result (has_result),
    .res        (res)
  );

  // The held byte moves on when it needs no result slot or the slot is free.
  assign out_free    = !result_valid || !result_stall;
  assign fire        = in_q_valid && (!has_result || out_free);
  assign frame_stall = in_q_valid && !fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (frame_valid && !frame_stall) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      in_q <= frame;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      result <= res;
    end
  end

endmodule

FILE: hw/rtl/cfd_checker.sv
// Port-level checks on the frame deframer's result channel.
module cfd_checker
  import cfd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  // Every result item carries a payload byte or closes a frame.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.payload_valid || result.done_res)
    else $error("result item with neither payload nor frame end");

  // Frame summary fields are zero except on the closing item.
  a_summary: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.done_res |->
      result.status == ST_OK && result.command_kind == KIND_OK &&
      result.payload_count == 8'd0)
    else $error("frame summary on a non-final item");

  // Command kind is reported only for accepted or CRC-failed frames.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.command_kind != KIND_OK |->
      result.status == ST_OK || result.status == ST_BAD_CRC)
    else $error("command kind with a non-CRC failure");

  // Outside the payload window the byte reads as zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.payload_valid |-> result.payload_byte == 8'd0)
    else $error("non-payload byte not zero");

endmodule

bind crc16_frame_deframer_core cfd_checker u_cfd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
